### rtl/gvw_pkg.sv
// Shared types, constants and helpers of the grid ray voxel walker.
package gvw_pkg;

   localparam int MAX_CELLS_DEF = 512;
   localparam int FRAC_BITS_DEF = 16;

   localparam int T_W   = 32;
   localparam int MUL_W = 33;
   localparam int DEN_W = 33;
   localparam int DIV_W = 62;
   localparam int CNT_FIELD_W = 10;
   localparam int IDX_W = 27;
   localparam int OUT_CELL_W = 9;

   localparam logic signed [T_W-1:0] T_NEVER = 32'sh7fff_ffff;
   localparam logic signed [T_W-1:0] T_FLOOR = 32'sh8000_0000;

   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   localparam logic [1:0] STAT_VALID = 2'd0;
   localparam logic [1:0] STAT_MISS  = 2'd1;
   localparam logic [1:0] STAT_DONE  = 2'd2;

   localparam logic [1:0] STEP_NONE = 2'b00;
   localparam logic [1:0] STEP_POS  = 2'b01;
   localparam logic [1:0] STEP_NEG  = 2'b11;
   localparam logic [1:0] STEP_BAD  = 2'b10;

   localparam logic [2:0] CSR_GMIN_X = 3'd0;
   localparam logic [2:0] CSR_GMIN_Y = 3'd1;
   localparam logic [2:0] CSR_GMIN_Z = 3'd2;
   localparam logic [2:0] CSR_SIZE_X = 3'd3;
   localparam logic [2:0] CSR_SIZE_Y = 3'd4;
   localparam logic [2:0] CSR_SIZE_Z = 3'd5;
   localparam logic [2:0] CSR_COUNTS = 3'd6;

   localparam logic signed [31:0] GMIN_RESET = 32'sd0;
   localparam logic [30:0] SIZE_RESET   = 31'd65536;
   localparam logic [29:0] COUNTS_RESET = 30'd1049601;

   typedef struct packed {
      logic go;
      logic frac;
   } div_req_type;

   // clip a 33-bit sum to the signed 32-bit range
   function automatic logic signed [T_W-1:0] sat33(input logic signed [T_W:0] v);
      logic signed [T_W-1:0] r;
      if (v[T_W] != v[T_W-1]) begin
         r = v[T_W] ? T_FLOOR : T_NEVER;
      end else begin
         r = v[T_W-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/gvw_div.sv
// Iterative restoring divider: floor(num * 2^FRAC_BITS / den), or floor(num / den) without frac, saturated to 32 bits.
module gvw_div #(
   parameter int FRAC_BITS = gvw_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  gvw_pkg::div_req_type               div_req,
   input  logic signed [66-FRAC_BITS-1:0]     num,
   input  logic signed [gvw_pkg::DEN_W-1:0]   den,
   output logic                               done,
   output logic signed [gvw_pkg::T_W-1:0]     quo
);
   import gvw_pkg::*;

   localparam int POS_W = 66 - FRAC_BITS;
   localparam int ITER_W = $clog2(DIV_W);

   logic              busy_ff, fin_ff, done_ff, neg_ff, sat_ff;
   logic [ITER_W-1:0] iter_ff;
   logic [DIV_W-1:0]  dvd_ff;
   logic [31:0]       rem_ff, ud_ff;
   logic signed [T_W-1:0] quo_ff;

   logic [POS_W-1:0] un_c;
   logic [31:0]      ud_c;
   logic [32:0]      trial;
   logic             ge;
   logic [DIV_W:0]   qn;
   logic signed [T_W-1:0] res_c;

   assign un_c  = num[POS_W-1] ? POS_W'(-num) : POS_W'(num);
   assign ud_c  = den[DEN_W-1] ? 32'(-den) : 32'(den);
   assign trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign ge    = trial >= {1'b0, ud_ff};
   assign qn    = {1'b0, dvd_ff} + (DIV_W+1)'(rem_ff != 32'd0);

   always_comb begin
      if (sat_ff) begin
         res_c = neg_ff ? T_FLOOR : T_NEVER;
      end else if (!neg_ff) begin
         res_c = (dvd_ff > DIV_W'(T_NEVER)) ? T_NEVER : T_W'(dvd_ff);
      end else begin
         res_c = (qn > (DIV_W+1)'(64'h8000_0000)) ? T_FLOOR : -T_W'(qn);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.go) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
            ud_ff   <= ud_c;
            rem_ff  <= '0;
            neg_ff  <= num[POS_W-1] != den[DEN_W-1];
            sat_ff  <= (ud_c == 32'd0) ||
                       (div_req.frac && ((un_c >> (62 - FRAC_BITS)) != '0));
            dvd_ff  <= div_req.frac ? (DIV_W'(un_c) << FRAC_BITS) : DIV_W'(un_c);
         end else if (busy_ff) begin
            dvd_ff  <= {dvd_ff[DIV_W-2:0], ge};
            rem_ff  <= ge ? 32'(trial - {1'b0, ud_ff}) : trial[31:0];
            iter_ff <= iter_ff + 1'b1;
            if (iter_ff == ITER_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
            quo_ff  <= res_c;
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

### rtl/grid_ray_voxel_walker.sv
// Top level of the grid ray voxel walker: sequencer, shared multiplier, result register.
//
// Walks the cells of a uniform 3D grid that a ray crosses, in Q16.16 fixed point.
// Input words (req_) carry op in tuser: start a ray or advance one cell. A start
// word carries origin, direction and the t range; an advance word's data is unused.
// Every input word yields exactly one result word (rsp_): cell x/y/z, linear cell
// index and a status in tuser (cell valid, ray misses grid, walk finished).
// The grid box and cell sizes are set through the csr_ write port; the user must write
// them only while idle, as the block does not enforce it. One word is worked at a time;
// req_tready is high only in the idle state. An advance does one compare and add, then
// the index through the shared multiplier, or goes straight to the result when it ends
// the walk. A start does up to fifteen divisions in the shared one-bit-per-cycle divider,
// plus multiplier steps for the box bound, start point, cell edge and cell index.
// The result sits in an output register; a new word is accepted while it waits,
// and the next result waits until rsp_tready frees that register.
// Synchronous reset clears the walk, the result register and the registers to
// their defaults (box at the origin, unit cells, one cell per axis).
module grid_ray_voxel_walker #(
   parameter int MAX_CELLS_PER_AXIS = gvw_pkg::MAX_CELLS_DEF,
   parameter int FRAC_BITS          = gvw_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // orig_x, orig_y, orig_z, dir_x, dir_y, dir_z, t_min, t_max
   input  logic [255:0] req_tdata,
   // op
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // cell_x, cell_y, cell_z, cell_index, 2 zero bits
   output logic [55:0]  rsp_tdata,
   // status
   output logic [1:0]   rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import gvw_pkg::*;

   localparam int NW    = $clog2(MAX_CELLS_PER_AXIS + 1);
   localparam int CW    = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
   localparam int POS_W = 66 - FRAC_BITS;

   typedef enum logic [19:0] {
      S_IDLE = 20'h00001, S_BMUL = 20'h00002, S_BMAX = 20'h00004,
      S_SLAB = 20'h00008, S_T0   = 20'h00010, S_T1   = 20'h00020,
      S_HIT  = 20'h00040, S_SMUL = 20'h00080, S_SPOS = 20'h00100,
      S_CGO  = 20'h00200, S_CDIV = 20'h00400, S_EMUL = 20'h00800,
      S_EDGE = 20'h01000, S_NDIV = 20'h02000, S_DDIV = 20'h04000,
      S_ADV  = 20'h08000, S_IX1  = 20'h10000, S_IX2  = 20'h20000,
      S_IX3  = 20'h40000, S_EMIT = 20'h80000
   } state_type;

   state_type state_ff, state_in;

   // registers
   logic signed [31:0] gmin_ff [3];
   logic [30:0]        size_ff [3];
   logic [29:0]        counts_ff;

   // ray setup
   logic signed [31:0] o_ff [3], d_ff [3];
   logic signed [31:0] tmin_ff, tmax_ff, tn_ff, tf_ff, t0_ff, tstart_ff;
   logic signed [POS_W-1:0] bmax_ff, start_ff [3];
   logic in_box_ff;
   logic [1:0] ax_ff;

   // walk state
   logic [CW-1:0]      cur_ff [3];
   logic signed [31:0] next_ff [3], delta_ff [3];
   logic [1:0]         step_ff [3];
   logic signed [31:0] exit_ff;
   logic               walking_ff;

   logic [1:0]       stat_ff;
   logic [IDX_W-1:0] idx_ff;

   logic signed [2*MUL_W-1:0] mul_p_ff;
   logic signed [MUL_W-1:0]   mul_a, mul_b;

   div_req_type             dreq_ff, dreq_in;
   logic signed [POS_W-1:0] dnum_ff;
   logic signed [DEN_W-1:0] dden_ff;
   logic                    div_done;
   logic signed [31:0]      div_quo;

   logic        rsp_valid_ff;
   logic [55:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   logic [NW-1:0] cnt [3];
   logic [30:0]   szv [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [CNT_FIELD_W:0] raw;
         raw = {1'b0, counts_ff[CNT_FIELD_W*i +: CNT_FIELD_W]};
         if (raw == '0) begin
            cnt[i] = NW'(1);
         end else if (raw > (CNT_FIELD_W+1)'(MAX_CELLS_PER_AXIS)) begin
            cnt[i] = NW'(MAX_CELLS_PER_AXIS);
         end else begin
            cnt[i] = NW'(raw);
         end
         szv[i] = (size_ff[i] == '0) ? 31'd1 : size_ff[i];
      end
   end

   // axis picks and checks
   logic signed [POS_W-1:0] o_ax, gmin_ax;
   logic signed [31:0]      d_ax;
   logic                    oob, dpos, d_zero;
   logic signed [31:0]      lo_t, hi_t, nm1, cl_c;
   logic [1:0]              adv_a;
   logic signed [CW+1:0]    adv_c;
   logic                    adv_end;
   logic [CW:0]             ce;

   assign o_ax    = POS_W'(o_ff[ax_ff]);
   assign gmin_ax = POS_W'(gmin_ff[ax_ff]);
   assign d_ax    = d_ff[ax_ff];
   assign dpos    = d_ax > 32'sd0;
   assign d_zero  = d_ax == 32'sd0;
   assign oob     = (o_ax < gmin_ax) || (o_ax > bmax_ff);
   assign lo_t    = (t0_ff < div_quo) ? t0_ff : div_quo;
   assign hi_t    = (t0_ff < div_quo) ? div_quo : t0_ff;
   assign nm1     = $signed(32'(cnt[ax_ff])) - 32'sd1;
   assign cl_c    = (div_quo < 32'sd0) ? 32'sd0 : ((div_quo > nm1) ? nm1 : div_quo);
   assign ce      = {1'b0, cur_ff[ax_ff]} + (CW+1)'(dpos);

   always_comb begin
      if (next_ff[0] < next_ff[1] && next_ff[0] < next_ff[2]) begin
         adv_a = 2'd0;
      end else if (next_ff[2] < next_ff[1]) begin
         adv_a = 2'd2;
      end else begin
         adv_a = 2'd1;
      end
      adv_c   = $signed({2'b00, cur_ff[adv_a]}) + (CW+2)'($signed(step_ff[adv_a]));
      adv_end = (exit_ff < next_ff[adv_a]) || (step_ff[adv_a] == STEP_NONE) ||
                adv_c[CW+1] || (adv_c >= $signed((CW+2)'(cnt[adv_a])));
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_BMUL: begin
            mul_a = $signed(MUL_W'(cnt[ax_ff]));
            mul_b = $signed(MUL_W'(szv[ax_ff]));
         end
         S_SMUL: begin
            mul_a = MUL_W'(d_ax);
            mul_b = MUL_W'(tstart_ff);
         end
         S_EMUL: begin
            mul_a = $signed(MUL_W'(ce));
            mul_b = $signed(MUL_W'(szv[ax_ff]));
         end
         S_IX1: begin
            mul_a = $signed(MUL_W'(cur_ff[2]));
            mul_b = $signed(MUL_W'(cnt[1]));
         end
         S_IX2: begin
            mul_a = $signed(mul_p_ff[MUL_W-1:0] + MUL_W'(cur_ff[1]));
            mul_b = $signed(MUL_W'(cnt[0]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
   end

   // divider launches
   always_comb begin
      dreq_in = '0;
      case (state_ff)
         S_SLAB: if (!d_zero) dreq_in = '{go: 1'b1, frac: 1'b1};
         S_T0:   if (div_done) dreq_in = '{go: 1'b1, frac: 1'b1};
         S_CGO:  dreq_in = '{go: 1'b1, frac: 1'b0};
         S_EDGE: dreq_in = '{go: 1'b1, frac: 1'b1};
         S_NDIV: if (div_done) dreq_in = '{go: 1'b1, frac: 1'b1};
         default: dreq_in = '0;
      endcase
   end

   gvw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (dreq_ff),
      .num     (dnum_ff),
      .den     (dden_ff),
      .done    (div_done),
      .quo     (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser[0] == OP_START) ? S_BMUL : S_ADV;
            end
         end
         S_BMUL: state_in = S_BMAX;
         S_BMAX: state_in = S_SLAB;
         S_SLAB: begin
            if (!d_zero) begin
               state_in = S_T0;
            end else if (oob) begin
               state_in = S_EMIT;
            end else begin
               state_in = (ax_ff == 2'd2) ? S_HIT : S_BMUL;
            end
         end
         S_T0: if (div_done) state_in = S_T1;
         S_T1: begin
            if (div_done) begin
               state_in = (ax_ff == 2'd2) ? S_HIT : S_BMUL;
            end
         end
         S_HIT: begin
            if (!(tn_ff <= tf_ff && tn_ff < tmax_ff && tf_ff > tmin_ff)) begin
               state_in = S_EMIT;
            end else begin
               state_in = in_box_ff ? S_CGO : S_SMUL;
            end
         end
         S_SMUL: state_in = S_SPOS;
         S_SPOS: state_in = (ax_ff == 2'd2) ? S_CGO : S_SMUL;
         S_CGO:  state_in = S_CDIV;
         S_CDIV: begin
            if (div_done) begin
               if (!d_zero) begin
                  state_in = S_EMUL;
               end else begin
                  state_in = (ax_ff == 2'd2) ? S_IX1 : S_CGO;
               end
            end
         end
         S_EMUL: state_in = S_EDGE;
         S_EDGE: state_in = S_NDIV;
         S_NDIV: if (div_done) state_in = S_DDIV;
         S_DDIV: begin
            if (div_done) begin
               state_in = (ax_ff == 2'd2) ? S_IX1 : S_CGO;
            end
         end
         S_ADV:  state_in = (!walking_ff || adv_end) ? S_EMIT : S_IX1;
         S_IX1:  state_in = S_IX2;
         S_IX2:  state_in = S_IX3;
         S_IX3:  state_in = S_EMIT;
         S_EMIT: if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         walking_ff <= 1'b0;
         dreq_ff    <= '0;
         for (int i = 0; i < 3; i++) begin
            cur_ff[i]   <= '0;
            next_ff[i]  <= '0;
            delta_ff[i] <= '0;
            step_ff[i]  <= STEP_NONE;
         end
         exit_ff <= '0;
      end else begin
         state_ff <= state_in;
         dreq_ff  <= dreq_in;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tuser[0] == OP_START) begin
                  for (int i = 0; i < 3; i++) begin
                     o_ff[i] <= req_tdata[32*i +: 32];
                     d_ff[i] <= req_tdata[96 + 32*i +: 32];
                  end
                  tmin_ff    <= req_tdata[223:192];
                  tmax_ff    <= req_tdata[255:224];
                  tn_ff      <= T_FLOOR;
                  tf_ff      <= T_NEVER;
                  in_box_ff  <= 1'b1;
                  ax_ff      <= 2'd0;
                  walking_ff <= 1'b0;
               end
            end
            S_BMAX: bmax_ff <= gmin_ax + POS_W'(mul_p_ff);
            S_SLAB: begin
               if (oob) in_box_ff <= 1'b0;
               if (!d_zero) begin
                  dnum_ff <= gmin_ax - o_ax;
                  dden_ff <= DEN_W'(d_ax);
               end else if (oob) begin
                  stat_ff <= STAT_MISS;
               end else begin
                  ax_ff <= ax_ff + 2'd1;
               end
            end
            S_T0: begin
               if (div_done) begin
                  t0_ff   <= div_quo;
                  dnum_ff <= bmax_ff - o_ax;
                  dden_ff <= DEN_W'(d_ax);
               end
            end
            S_T1: begin
               if (div_done) begin
                  if (lo_t > tn_ff) tn_ff <= lo_t;
                  if (hi_t < tf_ff) tf_ff <= hi_t;
                  ax_ff <= ax_ff + 2'd1;
               end
            end
            S_HIT: begin
               ax_ff   <= 2'd0;
               stat_ff <= STAT_MISS;
               if (in_box_ff) begin
                  tstart_ff <= '0;
                  exit_ff   <= tmax_ff;
                  for (int i = 0; i < 3; i++) start_ff[i] <= POS_W'(o_ff[i]);
               end else begin
                  tstart_ff <= tn_ff;
                  exit_ff   <= (tf_ff < tmax_ff) ? tf_ff : tmax_ff;
               end
            end
            S_SPOS: begin
               start_ff[ax_ff] <= o_ax + POS_W'(mul_p_ff >>> FRAC_BITS);
               ax_ff <= (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
            end
            S_CGO: begin
               dnum_ff <= start_ff[ax_ff] - gmin_ax;
               dden_ff <= $signed(DEN_W'(szv[ax_ff]));
            end
            S_CDIV: begin
               if (div_done) begin
                  cur_ff[ax_ff] <= CW'(cl_c);
                  if (d_zero) begin
                     next_ff[ax_ff]  <= T_NEVER;
                     delta_ff[ax_ff] <= '0;
                     step_ff[ax_ff]  <= STEP_NONE;
                     ax_ff <= ax_ff + 2'd1;
                     if (ax_ff == 2'd2) walking_ff <= 1'b1;
                  end else begin
                     step_ff[ax_ff] <= dpos ? STEP_POS : STEP_NEG;
                  end
               end
            end
            S_EDGE: begin
               dnum_ff <= POS_W'(mul_p_ff) + gmin_ax - start_ff[ax_ff];
               dden_ff <= DEN_W'(d_ax);
            end
            S_NDIV: begin
               if (div_done) begin
                  next_ff[ax_ff] <= sat33(33'(tstart_ff) + 33'(div_quo));
                  dnum_ff <= $signed(POS_W'(szv[ax_ff]));
                  dden_ff <= dpos ? DEN_W'(d_ax) : -DEN_W'(d_ax);
               end
            end
            S_DDIV: begin
               if (div_done) begin
                  delta_ff[ax_ff] <= div_quo;
                  ax_ff <= ax_ff + 2'd1;
                  if (ax_ff == 2'd2) walking_ff <= 1'b1;
               end
            end
            S_ADV: begin
               stat_ff <= STAT_DONE;
               if (walking_ff && adv_end) begin
                  walking_ff <= 1'b0;
               end else if (walking_ff) begin
                  cur_ff[adv_a]  <= CW'(adv_c);
                  next_ff[adv_a] <= sat33(33'(next_ff[adv_a]) + 33'(delta_ff[adv_a]));
               end
            end
            S_IX3: begin
               idx_ff  <= mul_p_ff[IDX_W-1:0] + IDX_W'(cur_ff[0]);
               stat_ff <= STAT_VALID;
            end
            default: begin
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_EMIT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_ff <= 1'b1;
         rsp_user_ff  <= stat_ff;
         if (stat_ff == STAT_VALID) begin
            rsp_data_ff <= {2'b00, idx_ff, OUT_CELL_W'(cur_ff[2]),
                            OUT_CELL_W'(cur_ff[1]), OUT_CELL_W'(cur_ff[0])};
         end else begin
            rsp_data_ff <= '0;
         end
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            gmin_ff[i] <= GMIN_RESET;
            size_ff[i] <= SIZE_RESET;
         end
         counts_ff <= COUNTS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GMIN_X: gmin_ff[0] <= csr_wdata;
            CSR_GMIN_Y: gmin_ff[1] <= csr_wdata;
            CSR_GMIN_Z: gmin_ff[2] <= csr_wdata;
            CSR_SIZE_X: size_ff[0] <= csr_wdata[30:0];
            CSR_SIZE_Y: size_ff[1] <= csr_wdata[30:0];
            CSR_SIZE_Z: size_ff[2] <= csr_wdata[30:0];
            CSR_COUNTS: counts_ff  <= csr_wdata[29:0];
            default: begin
            end
         endcase
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_off_duty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_VALID |-> rsp_tdata == '0)
      else $error("non-cell result carries cell data");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_T0 || state_ff == S_T1 || state_ff == S_CDIV ||
                   state_ff == S_NDIV || state_ff == S_DDIV)
      else $error("divider finished outside a wait state");

   a_step_code: assert property (@(posedge clock) disable iff (reset)
      step_ff[0] != STEP_BAD && step_ff[1] != STEP_BAD && step_ff[2] != STEP_BAD)
      else $error("bad step code");

endmodule

### tb/grid_ray_voxel_walker_tb.sv
// Self-checking bench for the grid ray voxel walker: directed words, then random ray walks.
`timescale 1ns / 100ps

module grid_ray_voxel_walker_tb;
   import gvw_pkg::*;

   localparam int  CYCLE_LIMIT = 6_000_000;
   localparam int  PHASES      = 6;
   localparam int  WORDS_PER_PHASE = 280;
   localparam longint SMAX = 64'sd2147483647;
   localparam longint SMIN = -64'sd2147483648;

   typedef struct packed {
      logic [26:0] idx;
      logic [8:0]  cz;
      logic [8:0]  cy;
      logic [8:0]  cx;
      logic [1:0]  st;
   } cell_word_t;

   typedef struct {
      logic         op;
      logic [255:0] data;
      bit           typed;
      logic [1:0]   st;
   } req_row_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [255:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [55:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_wr_en = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   // predictor copy of registers and walk state
   longint grid_lo[3];
   longint cell_w[3];
   longint counts_reg;
   longint walk_cell[3];
   longint walk_next[3];
   longint walk_delta[3];
   longint walk_step[3];
   longint walk_exit;
   bit     walk_active;

   cell_word_t cell_q[$];
   int  mismatches = 0;
   int  cycles = 0;
   bit  quiet = 1'b0;
   int  stall_left = 0;

   grid_ray_voxel_walker DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint axis_count(int a);
      longint n;
      n = (counts_reg >> (10 * a)) & 64'h3ff;
      if (n < 1) n = 1;
      if (n > 512) n = 512;
      return n;
   endfunction

   function automatic longint axis_size(int a);
      return (cell_w[a] == 0) ? 64'sd1 : cell_w[a];
   endfunction

   function automatic longint sat_t(longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
   endfunction

   // floor(num * 2^sh / den), saturated to 32 bits
   function automatic longint fx_div(longint num, longint den, int sh);
      longint unsigned un, ud, q, r;
      bit neg;
      un = (num < 0) ? longint'(-num) : num;
      ud = (den < 0) ? longint'(-den) : den;
      neg = (num < 0) != (den < 0);
      if (ud == 0 || un >= (64'd1 << (62 - sh))) return neg ? SMIN : SMAX;
      q = (un << sh) / ud;
      r = (un << sh) % ud;
      if (!neg) return (q > 64'd2147483647) ? SMAX : longint'(q);
      if (r != 0) q++;
      if (q > 64'd2147483648) return SMIN;
      return -longint'(q);
   endfunction

   function automatic cell_word_t cell_out(logic [1:0] st);
      cell_word_t w;
      longint nx, ny;
      w = '0;
      w.st = st;
      if (st == STAT_VALID) begin
         nx = axis_count(0);
         ny = axis_count(1);
         w.cx = walk_cell[0][8:0];
         w.cy = walk_cell[1][8:0];
         w.cz = walk_cell[2][8:0];
         w.idx = 27'(walk_cell[2] * ny * nx + walk_cell[1] * nx + walk_cell[0]);
      end
      return w;
   endfunction

   function automatic cell_word_t walk_predict(logic op, logic [255:0] d);
      longint o[3], dv[3], bmax[3], org[3];
      longint tn, tf, tmin, tmax, t0, t1, tstart, n, sz, c, edge_pos;
      bit in_box;
      int a;
      if (op == OP_ADVANCE) begin
         if (!walk_active) return cell_out(STAT_DONE);
         if (walk_next[0] < walk_next[1] && walk_next[0] < walk_next[2]) a = 0;
         else if (walk_next[2] < walk_next[1]) a = 2;
         else a = 1;
         c = walk_cell[a] + walk_step[a];
         if (walk_exit < walk_next[a] || walk_step[a] == 0 || c < 0 ||
             c >= axis_count(a)) begin
            walk_active = 1'b0;
            return cell_out(STAT_DONE);
         end
         walk_cell[a] = c;
         walk_next[a] = sat_t(walk_next[a] + walk_delta[a]);
         return cell_out(STAT_VALID);
      end
      walk_active = 1'b0;
      tn = SMIN;
      tf = SMAX;
      tmin = longint'($signed(d[223:192]));
      tmax = longint'($signed(d[255:224]));
      in_box = 1'b1;
      for (int i = 0; i < 3; i++) begin
         o[i] = longint'($signed(d[32*i +: 32]));
         dv[i] = longint'($signed(d[32*(i+3) +: 32]));
         bmax[i] = grid_lo[i] + axis_count(i) * axis_size(i);
         if (o[i] < grid_lo[i] || o[i] > bmax[i]) in_box = 1'b0;
         if (dv[i] == 0) begin
            if (o[i] < grid_lo[i] || o[i] > bmax[i]) return cell_out(STAT_MISS);
         end else begin
            t0 = fx_div(grid_lo[i] - o[i], dv[i], 16);
            t1 = fx_div(bmax[i] - o[i], dv[i], 16);
            if (((t0 < t1) ? t0 : t1) > tn) tn = (t0 < t1) ? t0 : t1;
            if (((t0 < t1) ? t1 : t0) < tf) tf = (t0 < t1) ? t1 : t0;
         end
      end
      if (!(tn <= tf && tn < tmax && tf > tmin)) return cell_out(STAT_MISS);
      if (in_box) begin
         tstart = 0;
         walk_exit = tmax;
         for (int i = 0; i < 3; i++) org[i] = o[i];
      end else begin
         tstart = tn;
         walk_exit = (tf < tmax) ? tf : tmax;
         for (int i = 0; i < 3; i++) org[i] = o[i] + ((dv[i] * tstart) >>> 16);
      end
      for (int i = 0; i < 3; i++) begin
         n = axis_count(i);
         sz = axis_size(i);
         c = fx_div(org[i] - grid_lo[i], sz, 0);
         if (c < 0) c = 0;
         if (c > n - 1) c = n - 1;
         walk_cell[i] = c;
         if (dv[i] > 0) begin
            edge_pos = (c + 1) * sz + grid_lo[i];
            walk_next[i] = sat_t(tstart + fx_div(edge_pos - org[i], dv[i], 16));
            walk_delta[i] = fx_div(sz, dv[i], 16);
            walk_step[i] = 1;
         end else if (dv[i] < 0) begin
            edge_pos = c * sz + grid_lo[i];
            walk_next[i] = sat_t(tstart + fx_div(edge_pos - org[i], dv[i], 16));
            walk_delta[i] = fx_div(sz, -dv[i], 16);
            walk_step[i] = -1;
         end else begin
            walk_next[i] = SMAX;
            walk_delta[i] = 0;
            walk_step[i] = 0;
         end
      end
      walk_active = 1'b1;
      return cell_out(STAT_VALID);
   endfunction

   // enter at a falling edge, leave at the falling edge after acceptance
   task automatic send_word(logic op, logic [255:0] d, bit typed, logic [1:0] st);
      cell_word_t w;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      w = walk_predict(op, d);
      if (typed) begin
         w = '0;
         w.st = st;
      end
      cell_q.push_back(w);
      @(negedge clock);
   endtask

   task automatic apply_setting(longint v[7]);
      logic [2:0] order[7];
      order = '{CSR_GMIN_X, CSR_GMIN_Y, CSR_GMIN_Z, CSR_SIZE_X, CSR_SIZE_Y,
                CSR_SIZE_Z, CSR_COUNTS};
      req_tvalid <= 1'b0;
      while (cell_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      for (int i = 0; i < 7; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= 32'(v[i]);
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      for (int i = 0; i < 3; i++) begin
         grid_lo[i] = longint'($signed(v[i][31:0]));
         cell_w[i] = v[i+3] & 64'h7fffffff;
      end
      counts_reg = v[6] & 64'h3fffffff;
   endtask

   // a ray aimed in and around the current box
   function automatic logic [255:0] aimed_ray();
      logic [255:0] d;
      longint span, pos, dir;
      for (int i = 0; i < 3; i++) begin
         span = axis_count(i) * axis_size(i);
         pos = grid_lo[i] + (span * $urandom_range(0, 1500)) / 1000 - span / 4;
         d[32*i +: 32] = 32'(pos);
         case ($urandom_range(0, 9))
            0: dir = 0;
            1: dir = longint'($signed($urandom()));
            default: dir = $urandom_range(1, 32'h30000);
         endcase
         if ($urandom_range(0, 1)) dir = -dir;
         d[32*(i+3) +: 32] = 32'(dir);
      end
      d[223:192] = ($urandom_range(0, 3) == 0) ? $urandom() : -32'($urandom_range(0, 32'h40000));
      d[255:224] = ($urandom_range(0, 1) == 0) ? 32'h7fffffff : $urandom();
      return d;
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && !reset && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cell_word_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[53:0], rsp_tuser};
         if (cell_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
         end else begin
            want = cell_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"cell mismatch: exp x=%0d y=%0d z=%0d idx=%0d st=%0d, ",
                            "got x=%0d y=%0d z=%0d idx=%0d st=%0d"},
                           want.cx, want.cy, want.cz, want.idx, want.st,
                           got.cx, got.cy, got.cz, got.idx, got.st);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("grid_ray_voxel_walker_tb: done, errors");
         $finish;
      end
   end

   initial begin
      req_row_t rows[12];
      longint setting[PHASES][7];
      logic [255:0] d;
      int left;
      setting[0] = '{0, 0, 0, 65536, 65536, 65536, 64'h1004 << 8 | 4};
      setting[1] = '{-196608, -163840, 65536, 32768, 131072, 81920,
                     (5 << 20) | (3 << 10) | 8};
      setting[2] = '{64'h80000000, 64'h7fffffff, 0, 64'h7fffffff, 1, 65536,
                     64'h3fffffff};
      setting[3] = '{0, 0, 0, 4096, 4096, 0, (16 << 20) | (16 << 10) | 0};
      setting[4] = '{65536, -65536, 32768, 65536, 65536, 65536,
                     (2 << 20) | (12 << 10) | 7};
      setting[5] = '{0, 0, 0, 65536, 65536, 65536, (6 << 20) | (6 << 10) | 6};
      for (int i = 0; i < 3; i++) begin
         grid_lo[i] = 0;
         cell_w[i] = 65536;
         walk_cell[i] = 0;
         walk_next[i] = 0;
         walk_delta[i] = 0;
         walk_step[i] = 0;
      end
      counts_reg = 1049601;
      walk_exit = 0;
      walk_active = 1'b0;
      // fields: orig_x, orig_y, orig_z, dir_x, dir_y, dir_z, t_min, t_max (low to high)
      rows[0]  = '{OP_ADVANCE, '0, 1'b1, STAT_DONE};
      rows[1]  = '{OP_START, {32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h10000,
                   32'h8000, 32'h8000, 32'h8000}, 1'b1, STAT_VALID};
      rows[2]  = '{OP_ADVANCE, '0, 1'b1, STAT_DONE};
      rows[3]  = '{OP_START, {32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h0,
                   32'h8000, 32'h8000, 32'h20000}, 1'b1, STAT_MISS};
      rows[4]  = '{OP_START, {32'h7fffffff, 32'h0, 32'h0, 32'h4000, 32'h10000,
                   32'h8000, 32'h8000, 32'hffff0000}, 1'b0, STAT_VALID};
      rows[5]  = '{OP_ADVANCE, '0, 1'b0, STAT_VALID};
      rows[6]  = '{OP_START, {32'h7fffffff, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff}, 1'b0, STAT_VALID};
      rows[7]  = '{OP_START, {32'h80000000, 32'h0, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000},
                   1'b1, STAT_MISS};
      rows[8]  = '{OP_START, {32'h7fffffff, 32'h7fffffff, 32'h10000, 32'h10000,
                   32'h10000, 32'h8000, 32'h8000, 32'h8000}, 1'b1, STAT_MISS};
      rows[9]  = '{OP_START, {32'h0, 32'h0, 32'hffff0000, 32'hffff8000,
                   32'hffffc000, 32'h4000, 32'h4000, 32'h4000}, 1'b0, STAT_VALID};
      rows[10] = '{OP_ADVANCE, '0, 1'b0, STAT_VALID};
      rows[11] = '{OP_START, {32'h7fffffff, 32'h0, 32'h0, 32'h10000, 32'h0,
                   32'h8000, 32'h8000, 32'hffff0000}, 1'b0, STAT_VALID};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (rows[r]) send_word(rows[r].op, rows[r].data, rows[r].typed, rows[r].st);
      for (int p = 0; p < PHASES; p++) begin
         apply_setting(setting[p]);
         left = WORDS_PER_PHASE;
         while (left > 0) begin
            if (p == PHASES - 1 && left < 120) quiet = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
               // noise: any bits at all, or a stray advance
               d = {$urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(), $urandom()};
               send_word(1'($urandom_range(0, 1)), d, 1'b0, STAT_VALID);
               left--;
            end else begin
               send_word(OP_START, aimed_ray(), 1'b0, STAT_VALID);
               left--;
               repeat ($urandom_range(1, 40)) begin
                  send_word(OP_ADVANCE, {8{$urandom()}}, 1'b0, STAT_VALID);
                  left--;
               end
            end
         end
      end
      req_tvalid <= 1'b0;
      while (cell_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0 && cell_q.size() == 0) begin
         $display("grid_ray_voxel_walker_tb: done, clean");
      end else begin
         $display("grid_ray_voxel_walker_tb: done, errors");
      end
      $finish;
   end

endmodule

### grid_ray_voxel_walker.f
rtl/gvw_pkg.sv
rtl/gvw_div.sv
rtl/grid_ray_voxel_walker.sv
tb/grid_ray_voxel_walker_tb.sv
